@@ src/tau_pkg.sv @@
// Shared types, constants and step functions of the torsion angle unit.
// Used by torsion_angle_unit_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tau_pkg;

  localparam int CW         = 21;
  localparam int PW         = 42;
  localparam int DOTW       = 86;
  localparam int PTW        = 65;
  localparam int WINW       = 40;
  localparam int NW         = 96;

  localparam logic [WINW-1:0] MIN_SQ_RESET = 40'd500000;
  localparam logic [WINW-1:0] MAX_SQ_RESET = 40'd9000000;

  localparam logic REG_MIN_SQ = 1'b0;
  localparam logic REG_MAX_SQ = 1'b1;

  localparam int SQ_BITS    = 30;
  localparam int SQ_PER     = 2;
  localparam int SQ_STAGES  = SQ_BITS / SQ_PER;

  localparam int NORM_STEPS  = 7;
  localparam int NORM_PER    = 2;
  localparam int NORM_STAGES = (NORM_STEPS + NORM_PER - 1) / NORM_PER;
  localparam int NORM_KEEP   = 30;

  localparam int CORDIC_STEPS = 26;
  localparam int CD_PER       = 2;
  localparam int CD_STAGES    = CORDIC_STEPS / CD_PER;

  localparam logic signed [32:0] ANG_90  = 33'sd589824000;
  localparam logic signed [32:0] ANG_180 = 33'sd1179648000;
  localparam logic signed [32:0] ANG_HALF_LSB = 33'sd32768;
  localparam logic signed [15:0] ANG_RIGHT = 16'sd9000;

  localparam int ATAB [CORDIC_STEPS] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
    22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11
  };

  localparam int NEXT1 [3] = '{1, 2, 0};
  localparam int NEXT2 [3] = '{2, 0, 1};

  typedef struct packed {
    logic                   ok;
    logic signed [DOTW-1:0] dot;
    logic signed [PTW-1:0]  pt;
  } side_t;

  typedef struct packed {
    side_t                 side;
    logic [2*SQ_BITS-1:0]  rad;
    logic [SQ_BITS+1:0]    rem;
    logic [SQ_BITS-1:0]    root;
  } sq_t;

  typedef struct packed {
    logic          ok;
    logic          zero;
    logic          neg;
    logic          xneg;
    logic [NW-1:0] x;
    logic [NW-1:0] y;
  } nm_t;

  typedef struct packed {
    logic               ok;
    logic               zero;
    logic               neg;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] acc;
  } cd_t;

  function automatic logic in_rng(logic signed [33:0] d);
    return (d <= 34'sd1048575) && (d >= -34'sd1048575);
  endfunction

  function automatic sq_t sqrt_step(sq_t s);
    sq_t r;
    logic [SQ_BITS+2:0] tr;
    logic [SQ_BITS+2:0] tt;
    logic [SQ_BITS+2:0] df;
    r  = s;
    tr = {s.rem[SQ_BITS:0], s.rad[2*SQ_BITS-1 -: 2]};
    tt = {1'b0, s.root, 2'b01};
    df = tr - tt;
    r.rad = {s.rad[2*SQ_BITS-3:0], 2'b00};
    if (tr >= tt) begin
      r.rem  = df[SQ_BITS+1:0];
      r.root = {s.root[SQ_BITS-2:0], 1'b1};
    end else begin
      r.rem  = tr[SQ_BITS+1:0];
      r.root = {s.root[SQ_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic nm_t norm_step(nm_t n, int unsigned k);
    nm_t r;
    logic [NW-1:0] orv;
    r   = n;
    orv = n.x | n.y;
    if (|(orv >> (NORM_KEEP - 1 + k))) begin
      r.x = n.x >> k;
      r.y = n.y >> k;
    end
    return r;
  endfunction

  function automatic cd_t cordic_step(cd_t c, int unsigned i);
    cd_t r;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    r  = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.y > 0) begin
      r.x   = c.x + dx;
      r.y   = c.y - dy;
      r.acc = c.acc + 33'(ATAB[i]);
    end else begin
      r.x   = c.x - dx;
      r.y   = c.y + dy;
      r.acc = c.acc - 33'(ATAB[i]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/torsion_angle_unit_top.sv @@
// Signed torsion angle of four 3D points, fully pipelined.
// Depends on tau_pkg for types, constants and the per-step functions.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one beat of four points per clock and returns one beat with the torsion
// angle in hundredths of a degree and a flag that says whether all coordinate differences
// were in range and all three squared bond lengths fell inside the window set by the two APB
// registers. Most stages are in the square root (two result bits per stage), the normalizing
// shifter and the 26-step CORDIC (two steps per stage). The pipeline stalls while the output
// beat is not taken, so in_ready_o follows out_ready_i whenever the output register is full.

module torsion_angle_unit_top import tau_pkg::*; #(
  parameter int COORD_BITS = 21
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire        [3:0]            paddr,
  input  wire        [63:0]           pwdata,
  output logic       [63:0]           prdata,
  output logic                        pready,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire signed [COORD_BITS-1:0] a_x_i,
  input  wire signed [COORD_BITS-1:0] a_y_i,
  input  wire signed [COORD_BITS-1:0] a_z_i,
  input  wire signed [COORD_BITS-1:0] b_x_i,
  input  wire signed [COORD_BITS-1:0] b_y_i,
  input  wire signed [COORD_BITS-1:0] b_z_i,
  input  wire signed [COORD_BITS-1:0] c_x_i,
  input  wire signed [COORD_BITS-1:0] c_y_i,
  input  wire signed [COORD_BITS-1:0] c_z_i,
  input  wire signed [COORD_BITS-1:0] d_x_i,
  input  wire signed [COORD_BITS-1:0] d_y_i,
  input  wire signed [COORD_BITS-1:0] d_z_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic signed [15:0]          angle_centideg_o,
  output logic                        valid_res_o
);

  logic [WINW-1:0] min_q, min_d, max_q, max_d;
  logic            cfg_we;
  logic            en;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (cfg_we) begin
      unique case (paddr[3])
        REG_MIN_SQ: min_d = pwdata[WINW-1:0];
        REG_MAX_SQ: max_d = pwdata[WINW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_MIN_SQ: prdata = 64'(min_q);
      REG_MAX_SQ: prdata = 64'(max_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_SQ_RESET;
      max_q <= MAX_SQ_RESET;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  logic out_valid_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  // Stage 1: differences and the coarse magnitude check.
  logic signed [COORD_BITS-1:0] pa [3], pb [3], pc [3], pd [3];
  assign pa[0] = a_x_i;
  assign pa[1] = a_y_i;
  assign pa[2] = a_z_i;
  assign pb[0] = b_x_i;
  assign pb[1] = b_y_i;
  assign pb[2] = b_z_i;
  assign pc[0] = c_x_i;
  assign pc[1] = c_y_i;
  assign pc[2] = c_z_i;
  assign pd[0] = d_x_i;
  assign pd[1] = d_y_i;
  assign pd[2] = d_z_i;

  logic signed [COORD_BITS:0] du_w [3], dv_w [3], dw_w [3];
  logic signed [33:0]         ue [3], ve [3], we [3];
  logic                       s1_ok_d;

  always_comb begin
    s1_ok_d = 1'b1;
    for (int j = 0; j < 3; j++) begin
      du_w[j] = (COORD_BITS+1)'(pa[j]) - (COORD_BITS+1)'(pb[j]);
      dv_w[j] = (COORD_BITS+1)'(pc[j]) - (COORD_BITS+1)'(pb[j]);
      dw_w[j] = (COORD_BITS+1)'(pd[j]) - (COORD_BITS+1)'(pc[j]);
      ue[j]   = 34'(du_w[j]);
      ve[j]   = 34'(dv_w[j]);
      we[j]   = 34'(dw_w[j]);
      s1_ok_d = s1_ok_d & in_rng(ue[j]) & in_rng(ve[j]) & in_rng(we[j]);
    end
  end

  logic                 s1_v_q, s1_ok_q;
  logic signed [CW-1:0] s1_du_q [3], s1_dv_q [3], s1_dw_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ok_q <= s1_ok_d;
      for (int j = 0; j < 3; j++) begin
        s1_du_q[j] <= ue[j][CW-1:0];
        s1_dv_q[j] <= ve[j][CW-1:0];
        s1_dw_q[j] <= we[j][CW-1:0];
      end
    end
  end

  // Stage 2: squares and cross-product terms.
  logic signed [PW-1:0] squ [3], sqv [3], sqw [3];
  logic signed [PW-1:0] pn1a [3], pn1b [3], pvwa [3], pvwb [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      squ[j]  = s1_du_q[j] * s1_du_q[j];
      sqv[j]  = s1_dv_q[j] * s1_dv_q[j];
      sqw[j]  = s1_dw_q[j] * s1_dw_q[j];
      pn1a[j] = s1_du_q[NEXT1[j]] * s1_dv_q[NEXT2[j]];
      pn1b[j] = s1_du_q[NEXT2[j]] * s1_dv_q[NEXT1[j]];
      pvwa[j] = s1_dv_q[NEXT1[j]] * s1_dw_q[NEXT2[j]];
      pvwb[j] = s1_dv_q[NEXT2[j]] * s1_dw_q[NEXT1[j]];
    end
  end

  logic                 s2_v_q, s2_ok_q;
  logic [WINW-1:0]      s2_squ_q [3], s2_sqv_q [3], s2_sqw_q [3];
  logic signed [PW-1:0] s2_n1a_q [3], s2_n1b_q [3], s2_vwa_q [3], s2_vwb_q [3];
  logic signed [CW-1:0] s2_du_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ok_q <= s1_ok_q;
      for (int j = 0; j < 3; j++) begin
        s2_squ_q[j] <= squ[j][WINW-1:0];
        s2_sqv_q[j] <= sqv[j][WINW-1:0];
        s2_sqw_q[j] <= sqw[j][WINW-1:0];
        s2_n1a_q[j] <= pn1a[j];
        s2_n1b_q[j] <= pn1b[j];
        s2_vwa_q[j] <= pvwa[j];
        s2_vwb_q[j] <= pvwb[j];
        s2_du_q[j]  <= s1_du_q[j];
      end
    end
  end

  // Stage 3: normals and squared lengths.
  logic                 s3_v_q, s3_ok_q;
  logic [WINW+1:0]      s3_su_q, s3_sv_q, s3_sw_q;
  logic signed [PW-1:0] s3_n1_q [3], s3_vw_q [3];
  logic signed [CW-1:0] s3_du_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_ok_q <= s2_ok_q;
      s3_su_q <= 42'(s2_squ_q[0]) + 42'(s2_squ_q[1]) + 42'(s2_squ_q[2]);
      s3_sv_q <= 42'(s2_sqv_q[0]) + 42'(s2_sqv_q[1]) + 42'(s2_sqv_q[2]);
      s3_sw_q <= 42'(s2_sqw_q[0]) + 42'(s2_sqw_q[1]) + 42'(s2_sqw_q[2]);
      for (int j = 0; j < 3; j++) begin
        s3_n1_q[j] <= s2_n1a_q[j] - s2_n1b_q[j];
        s3_vw_q[j] <= s2_vwa_q[j] - s2_vwb_q[j];
        s3_du_q[j] <= s2_du_q[j];
      end
    end
  end

  // Stage 4: window check and partial products of the two dot products.
  logic [WINW+1:0]      lo_w, hi_w;
  logic                 win_ok;
  logic signed [62:0]   pph [3], ptp [3];
  logic signed [63:0]   ppl [3];

  assign lo_w   = 42'(min_q);
  assign hi_w   = 42'(max_q);
  assign win_ok = (s3_su_q >= lo_w) && (s3_su_q <= hi_w) &&
                  (s3_sv_q >= lo_w) && (s3_sv_q <= hi_w) &&
                  (s3_sw_q >= lo_w) && (s3_sw_q <= hi_w);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pph[j] = s3_n1_q[j] * $signed(s3_vw_q[j][PW-1:CW]);
      ppl[j] = s3_n1_q[j] * $signed({1'b0, s3_vw_q[j][CW-1:0]});
      ptp[j] = s3_du_q[j] * s3_vw_q[j];
    end
  end

  logic                 s4_v_q, s4_ok_q;
  logic [WINW-1:0]      s4_vsq_q;
  logic signed [62:0]   s4_pph_q [3], s4_ptp_q [3];
  logic signed [63:0]   s4_ppl_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_ok_q  <= s3_ok_q & win_ok;
      s4_vsq_q <= s3_sv_q[WINW-1:0];
      for (int j = 0; j < 3; j++) begin
        s4_pph_q[j] <= pph[j];
        s4_ppl_q[j] <= ppl[j];
        s4_ptp_q[j] <= ptp[j];
      end
    end
  end

  // Stage 5: recombined products and the triple product.
  logic                   s5_v_q, s5_ok_q;
  logic [WINW-1:0]        s5_vsq_q;
  logic signed [83:0]     s5_prod_q [3];
  logic signed [PTW-1:0]  s5_pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_ok_q  <= s4_ok_q;
      s5_vsq_q <= s4_vsq_q;
      s5_pt_q  <= 65'(s4_ptp_q[0]) + 65'(s4_ptp_q[1]) + 65'(s4_ptp_q[2]);
      for (int j = 0; j < 3; j++) begin
        s5_prod_q[j] <= (84'(s4_pph_q[j]) <<< CW) + 84'(s4_ppl_q[j]);
      end
    end
  end

  // Square root of the scaled squared length of B to C.
  sq_t  sq_start;
  sq_t  sq_q [SQ_STAGES];
  logic sq_v_q [SQ_STAGES];

  always_comb begin
    sq_start.side.ok  = s5_ok_q;
    sq_start.side.dot = 86'(s5_prod_q[0]) + 86'(s5_prod_q[1]) + 86'(s5_prod_q[2]);
    sq_start.side.pt  = s5_pt_q;
    sq_start.rad      = {s5_vsq_q, 20'd0};
    sq_start.rem      = '0;
    sq_start.root     = '0;
  end

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sq
    sq_t  st_in, st_out;
    logic v_in;
    if (s == 0) begin : g_head
      assign st_in = sq_start;
      assign v_in  = s5_v_q;
    end else begin : g_body
      assign st_in = sq_q[s-1];
      assign v_in  = sq_v_q[s-1];
    end
    always_comb begin
      st_out = st_in;
      for (int t = 0; t < SQ_PER; t++) begin
        st_out = sqrt_step(st_out);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[s] <= 1'b0;
      end else if (en) begin
        sq_v_q[s] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[s] <= st_out;
      end
    end
  end

  // Magnitudes and the sine-side product.
  sq_t                   sq_last;
  logic [DOTW-1:0]       dmag;
  logic [PTW-1:0]        pmag;

  assign sq_last = sq_q[SQ_STAGES-1];
  assign dmag    = (sq_last.side.dot < 0) ? DOTW'(-sq_last.side.dot) : DOTW'(sq_last.side.dot);
  assign pmag    = (sq_last.side.pt < 0) ? PTW'(-sq_last.side.pt) : PTW'(sq_last.side.pt);

  logic          m1_v_q, m1_ok_q, m1_zero_q, m1_neg_q, m1_xneg_q;
  logic [84:0]   m1_xm_q;
  logic [61:0]   m1_ph_q, m1_pl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= sq_v_q[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_ok_q   <= sq_last.side.ok;
      m1_zero_q <= (sq_last.side.dot == '0) && (sq_last.side.pt == '0);
      m1_neg_q  <= sq_last.side.pt > 0;
      m1_xneg_q <= sq_last.side.dot > 0;
      m1_xm_q   <= dmag[84:0];
      m1_ph_q   <= pmag[63:32] * sq_last.root;
      m1_pl_q   <= pmag[31:0] * sq_last.root;
    end
  end

  logic m2_v_q;
  nm_t  m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_q.ok   <= m1_ok_q;
      m2_q.zero <= m1_zero_q;
      m2_q.neg  <= m1_neg_q;
      m2_q.xneg <= m1_xneg_q;
      m2_q.x    <= NW'(m1_xm_q) << 10;
      m2_q.y    <= (NW'(m1_ph_q) << 32) + NW'(m1_pl_q);
    end
  end

  // Normalizing shifter: the larger of the pair ends with at most 30 bits.
  nm_t  nm_q [NORM_STAGES];
  logic nm_v_q [NORM_STAGES];

  for (genvar s = 0; s < NORM_STAGES; s++) begin : g_nm
    nm_t  st_in, st_out;
    logic v_in;
    if (s == 0) begin : g_head
      assign st_in = m2_q;
      assign v_in  = m2_v_q;
    end else begin : g_body
      assign st_in = nm_q[s-1];
      assign v_in  = nm_v_q[s-1];
    end
    always_comb begin
      st_out = st_in;
      for (int t = 0; t < NORM_PER; t++) begin
        if (s * NORM_PER + t < NORM_STEPS) begin
          st_out = norm_step(st_out, 32'd1 << (NORM_STEPS - 1 - (s * NORM_PER + t)));
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nm_v_q[s] <= 1'b0;
      end else if (en) begin
        nm_v_q[s] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        nm_q[s] <= st_out;
      end
    end
  end

  // CORDIC vectoring.
  nm_t  nm_last;
  cd_t  cd_start;
  cd_t  cd_q [CD_STAGES];
  logic cd_v_q [CD_STAGES];

  assign nm_last = nm_q[NORM_STAGES-1];

  always_comb begin
    cd_start.ok   = nm_last.ok;
    cd_start.zero = nm_last.zero;
    cd_start.neg  = nm_last.neg;
    if (nm_last.xneg) begin
      cd_start.x   = $signed(34'(nm_last.y[NORM_KEEP-1:0]));
      cd_start.y   = $signed(34'(nm_last.x[NORM_KEEP-1:0]));
      cd_start.acc = ANG_90;
    end else begin
      cd_start.x   = $signed(34'(nm_last.x[NORM_KEEP-1:0]));
      cd_start.y   = $signed(34'(nm_last.y[NORM_KEEP-1:0]));
      cd_start.acc = '0;
    end
  end

  for (genvar s = 0; s < CD_STAGES; s++) begin : g_cd
    cd_t  st_in, st_out;
    logic v_in;
    if (s == 0) begin : g_head
      assign st_in = cd_start;
      assign v_in  = nm_v_q[NORM_STAGES-1];
    end else begin : g_body
      assign st_in = cd_q[s-1];
      assign v_in  = cd_v_q[s-1];
    end
    always_comb begin
      st_out = st_in;
      for (int t = 0; t < CD_PER; t++) begin
        st_out = cordic_step(st_out, s * CD_PER + t);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cd_v_q[s] <= 1'b0;
      end else if (en) begin
        cd_v_q[s] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        cd_q[s] <= st_out;
      end
    end
  end

  // Clamp, round, sign and the output register.
  cd_t                cd_last;
  logic signed [32:0] clamp_w, round_w;
  logic signed [15:0] mag_w, ang_w, res_d;
  logic signed [15:0] angle_q;
  logic               vres_q;

  assign cd_last = cd_q[CD_STAGES-1];

  always_comb begin
    if (cd_last.acc < 0) begin
      clamp_w = '0;
    end else if (cd_last.acc > ANG_180) begin
      clamp_w = ANG_180;
    end else begin
      clamp_w = cd_last.acc;
    end
    round_w = clamp_w + ANG_HALF_LSB;
    mag_w   = cd_last.zero ? ANG_RIGHT : $signed(round_w[31:16]);
    ang_w   = cd_last.neg ? -mag_w : mag_w;
    res_d   = cd_last.ok ? ang_w : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cd_v_q[CD_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= res_d;
      vres_q  <= cd_last.ok;
    end
  end

  assign angle_centideg_o = angle_q;
  assign valid_res_o      = vres_q;

endmodule

`default_nettype wire
